// ===== hw/rtl/thh_pkg.sv =====
// ----------------------------------------------------------------------------
// thh_pkg
// shared types, constants and constituent table of the tide height predictor
// ----------------------------------------------------------------------------
package thh_pkg;

  localparam int ROM_SLOTS     = 64;
  localparam int IDX_W         = $clog2(ROM_SLOTS);
  localparam int NUM_TERMS_DEF = 31;

  localparam int TIME_W   = 40;
  localparam int EPOCH_W  = 39;
  localparam int LEVEL_W  = 20;
  localparam int HEIGHT_W = 20;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 39;

  localparam int HEIGHT_MAX = 524287;
  localparam int HEIGHT_MIN = -524288;

  localparam logic [LEVEL_W-1:0] MEAN_LEVEL_RST = 20'd173015;
  localparam logic [EPOCH_W-1:0] EPOCH_RST      = 39'd1546301340;

  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_LEVEL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH      = 4'd1;

  // sine polynomial coefficients, q30
  localparam logic [31:0] COEF_C1 = 32'd1686629713;
  localparam logic [31:0] COEF_C3 = 32'd693598668;
  localparam logic [31:0] COEF_C5 = 32'd85569306;
  localparam logic [31:0] COEF_C7 = 32'd5026995;
  localparam logic [31:0] COEF_C9 = 32'd172272;

  localparam logic [31:0] QTR_TURN = 32'h4000_0000;
  localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
  localparam logic [14:0] COS_MAX  = 15'h7fff;
  localparam logic [32:0] RND_Q15  = 33'd16384;

  localparam logic [63:0] RATE_DIV  = 64'd12960000000000;
  localparam logic [63:0] PHASE_DIV = 64'd360000;
  localparam logic [63:0] AMP_DIV   = 64'd10000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG0,
    ST_ANG1,
    ST_ANG2,
    ST_ANG3,
    ST_SQR,
    ST_POLY0,
    ST_HORN,
    ST_ROUND,
    ST_ACCUM,
    ST_FIN
  } thh_state_t;

  typedef struct packed {
    logic [63:0] rate;
    logic [31:0] phase;
    logic [15:0] amp;
  } thh_rom_t;

  typedef struct packed {
    logic [31:0] deg7;
    logic [19:0] ph3;
    logic [15:0] amp4;
  } thh_src_t;

  typedef struct packed {
    logic        en;
    logic [31:0] a;
    logic [31:0] b;
  } thh_mul_req_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } thh_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } thh_stat_t;

  // accumulator width: |sum| < (n + 4) * 2^30, plus a sign bit
  function automatic int acc_width(input int n);
    return $clog2(n + 4) + 31;
  endfunction

  // constituents in decimal units: deg/h * 1e7, deg * 1e3, m * 1e4
  function automatic thh_src_t rom_src(input int k);
    thh_src_t s;
    s = '0;
    case (k)
      0:  s = '{32'd289841042, 20'd209601, 16'd16236};
      1:  s = '{32'd300000000, 20'd30617,  16'd4758};
      2:  s = '{32'd284397295, 20'd263418, 16'd2846};
      3:  s = '{32'd300821373, 20'd196250, 16'd1624};
      4:  s = '{32'd150410686, 20'd357212, 16'd1031};
      5:  s = '{32'd139430356, 20'd59267,  16'd1272};
      6:  s = '{32'd149589314, 20'd354719, 16'd361};
      7:  s = '{32'd133986609, 20'd79892,  16'd415};
      8:  s = '{32'd279682084, 20'd187004, 16'd913};
      9:  s = '{32'd285125831, 20'd330693, 16'd824};
      10: s = '{32'd278953548, 20'd313497, 16'd306};
      11: s = '{32'd295284789, 20'd324568, 16'd1087};
      12: s = '{32'd299589333, 20'd15603,  16'd224};
      13: s = '{32'd310158958, 20'd14171,  16'd301};
      14: s = '{32'd294556253, 20'd245613, 16'd475};
      15: s = '{32'd155854433, 20'd22363,  16'd63};
      16: s = '{32'd161391017, 20'd77357,  16'd49};
      17: s = '{32'd128542862, 20'd127521, 16'd65};
      18: s = '{32'd134715145, 20'd152544, 16'd83};
      19: s = '{32'd579682084, 20'd38983,  16'd525};
      20: s = '{32'd589841042, 20'd232210, 16'd225};
      21: s = '{32'd574238337, 20'd87083,  16'd184};
      22: s = '{32'd590662415, 20'd39766,  16'd63};
      23: s = '{32'd600000000, 20'd20681,  16'd9};
      24: s = '{32'd869523127, 20'd346092, 16'd92};
      25: s = '{32'd864079380, 20'd33689,  16'd48};
      26: s = '{32'd879682084, 20'd165004, 16'd70};
      27: s = '{32'd440251729, 20'd128877, 16'd198};
      28: s = '{32'd429271398, 20'd201290, 16'd266};
      29: s = '{32'd10980331,  20'd104409, 16'd87};
      30: s = '{32'd5443747,   20'd48050,  16'd75};
      default: s = '0;
    endcase
    return s;
  endfunction

  // turns per second, unsigned 0.64, rounded long division
  function automatic logic [63:0] rate_of(input logic [31:0] d);
    logic [63:0] r;
    logic [63:0] q;
    int          i;
    r = 64'(d);
    q = '0;
    for (i = 0; i < 64; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= RATE_DIV) begin
        r    = r - RATE_DIV;
        q[0] = 1'b1;
      end
    end
    if ((r << 1) >= RATE_DIV) begin
      q = q + 64'd1;
    end
    return q;
  endfunction

  function automatic logic [31:0] phase_of(input logic [19:0] p);
    logic [63:0] n;
    n = (64'(p) << 32) + 64'd180000;
    return 32'(n / PHASE_DIV);
  endfunction

  function automatic logic [15:0] amp_of(input logic [15:0] a);
    logic [63:0] n;
    n = 64'(a) * 64'd16384 + 64'd5000;
    return 16'(n / AMP_DIV);
  endfunction

  function automatic logic [31:0] horner_coef(input logic [1:0] k);
    logic [31:0] c;
    case (k)
      2'd0:    c = COEF_C7;
      2'd1:    c = COEF_C5;
      2'd2:    c = COEF_C3;
      default: c = COEF_C1;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/thh_ifs.sv =====
// ----------------------------------------------------------------------------
// thh channel interfaces
// valid/ready channels for time input, height result and register writes
// ----------------------------------------------------------------------------
interface thh_in_if;
  logic                             valid;
  logic                             ready;
  logic [thh_pkg::TIME_W-1:0]       unix_time;

  modport source (output valid, output unix_time, input ready);
  modport sink   (input valid, input unix_time, output ready);
endinterface

interface thh_out_if;
  logic                             valid;
  logic                             ready;
  logic [thh_pkg::HEIGHT_W-1:0]     height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

interface thh_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [thh_pkg::CFG_IDX_W-1:0]    index;
  logic [thh_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/thh_rom.sv =====
// ----------------------------------------------------------------------------
// thh_rom
// constituent table in fixed point, registered read
// ----------------------------------------------------------------------------
module thh_rom (
  input  logic                       clk,
  input  logic [thh_pkg::IDX_W-1:0]  addr,
  output thh_pkg::thh_rom_t          q_r
);

  thh_pkg::thh_rom_t tab [thh_pkg::ROM_SLOTS];

  for (genvar g = 0; g < thh_pkg::ROM_SLOTS; g++) begin : g_ent
    localparam thh_pkg::thh_src_t SRC  = thh_pkg::rom_src(g);
    localparam logic [63:0]       RATE = thh_pkg::rate_of(SRC.deg7);
    localparam logic [31:0]       PH   = thh_pkg::phase_of(SRC.ph3);
    localparam logic [15:0]       AMP  = thh_pkg::amp_of(SRC.amp4);
    assign tab[g] = '{rate: RATE, phase: PH, amp: AMP};
  end

  always_ff @(posedge clk) begin
    q_r <= tab[addr];
  end

endmodule

// ===== hw/rtl/thh_mul.sv =====
// ----------------------------------------------------------------------------
// thh_mul
// shared 32 x 32 unsigned multiplier with registered product
// ----------------------------------------------------------------------------
module thh_mul (
  input  logic                  clk,
  input  thh_pkg::thh_mul_req_t req,
  output logic [63:0]           prod_r
);

  always_ff @(posedge clk) begin
    if (req.en) begin
      prod_r <= 64'(req.a) * 64'(req.b);
    end
  end

endmodule

// ===== hw/rtl/thh_seq.sv =====
// ----------------------------------------------------------------------------
// thh_seq
// term sequencer: angle, cosine polynomial and accumulation on one multiplier
// ----------------------------------------------------------------------------
module thh_seq #(
  parameter int NUM_TERMS = thh_pkg::NUM_TERMS_DEF,
  parameter int ACC_W     = thh_pkg::acc_width(NUM_TERMS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  thh_pkg::thh_ctl_t            ctl,
  input  logic [63:0]                  elapsed,
  input  logic [thh_pkg::LEVEL_W-1:0]  mean,
  input  thh_pkg::thh_rom_t            rom_q,
  input  logic [63:0]                  prod,
  output logic [thh_pkg::IDX_W-1:0]    rom_addr,
  output thh_pkg::thh_mul_req_t        mul_req,
  output logic [ACC_W-1:0]             acc,
  output thh_pkg::thh_stat_t           stat
);

  localparam int IDX_W = thh_pkg::IDX_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TERMS - 1);

  thh_pkg::thh_state_t state_r, state_nxt;

  logic [63:0]       e_r, e_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [31:0]       ang_r, ang_nxt;
  logic [1:0]        quad_r, quad_nxt;
  logic [30:0]       t_r, t_nxt;
  logic [31:0]       t2_r, t2_nxt;
  logic [1:0]        hstep_r, hstep_nxt;

  logic [31:0] ang_full;
  logic [31:0] poly;
  logic [32:0] rnd_sum;
  logic [17:0] mag_wide;
  logic [14:0] mag;
  logic [ACC_W-1:0] term;

  // shifted angle, polynomial step and rounded magnitude
  assign ang_full = ang_r + prod[31:0] + thh_pkg::QTR_TURN;
  assign poly     = thh_pkg::horner_coef(hstep_r) - prod[61:30];
  assign rnd_sum  = 33'(prod[61:30]) + thh_pkg::RND_Q15;
  assign mag_wide = rnd_sum[32:15];
  assign mag      = (mag_wide > 18'(thh_pkg::COS_MAX)) ? thh_pkg::COS_MAX : mag_wide[14:0];
  assign term     = ACC_W'(prod[29:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      thh_pkg::ST_IDLE:  if (ctl.start) state_nxt = thh_pkg::ST_ANG0;
      thh_pkg::ST_ANG0:  state_nxt = thh_pkg::ST_ANG1;
      thh_pkg::ST_ANG1:  state_nxt = thh_pkg::ST_ANG2;
      thh_pkg::ST_ANG2:  state_nxt = thh_pkg::ST_ANG3;
      thh_pkg::ST_ANG3:  state_nxt = thh_pkg::ST_SQR;
      thh_pkg::ST_SQR:   state_nxt = thh_pkg::ST_POLY0;
      thh_pkg::ST_POLY0: state_nxt = thh_pkg::ST_HORN;
      thh_pkg::ST_HORN:  if (hstep_r == 2'd3) state_nxt = thh_pkg::ST_ROUND;
      thh_pkg::ST_ROUND: state_nxt = thh_pkg::ST_ACCUM;
      thh_pkg::ST_ACCUM: begin
        state_nxt = (idx_r == IDX_LAST) ? thh_pkg::ST_FIN : thh_pkg::ST_ANG0;
      end
      thh_pkg::ST_FIN:   if (ctl.out_free) state_nxt = thh_pkg::ST_IDLE;
      default:           state_nxt = thh_pkg::ST_IDLE;
    endcase
  end

  // outputs: multiplier operands and status
  always_comb begin
    mul_req   = '0;
    stat.busy = (state_r != thh_pkg::ST_IDLE);
    stat.done = 1'b0;
    case (state_r)
      thh_pkg::ST_ANG0: mul_req = '{1'b1, rom_q.rate[31:0], e_r[31:0]};
      thh_pkg::ST_ANG1: mul_req = '{1'b1, rom_q.rate[31:0], e_r[63:32]};
      thh_pkg::ST_ANG2: mul_req = '{1'b1, rom_q.rate[63:32], e_r[31:0]};
      thh_pkg::ST_SQR:  mul_req = '{1'b1, {1'b0, t_r}, {1'b0, t_r}};
      thh_pkg::ST_POLY0: mul_req = '{1'b1, thh_pkg::COEF_C9, prod[61:30]};
      thh_pkg::ST_HORN: begin
        mul_req = '{1'b1, poly, (hstep_r == 2'd3) ? {1'b0, t_r} : t2_r};
      end
      thh_pkg::ST_ROUND: mul_req = '{1'b1, 32'(rom_q.amp), 32'(mag)};
      thh_pkg::ST_FIN:   stat.done = ctl.out_free;
      default:           mul_req = '0;
    endcase
  end

  // datapath
  always_comb begin
    e_nxt     = e_r;
    acc_nxt   = acc_r;
    idx_nxt   = idx_r;
    ang_nxt   = ang_r;
    quad_nxt  = quad_r;
    t_nxt     = t_r;
    t2_nxt    = t2_r;
    hstep_nxt = hstep_r;
    case (state_r)
      thh_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (ctl.start) begin
          e_nxt   = elapsed;
          acc_nxt = {{(ACC_W - thh_pkg::LEVEL_W){mean[thh_pkg::LEVEL_W-1]}}, mean} << 13;
        end
      end
      thh_pkg::ST_ANG1: ang_nxt = prod[63:32] - rom_q.phase;
      thh_pkg::ST_ANG2: ang_nxt = ang_r + prod[31:0];
      thh_pkg::ST_ANG3: begin
        quad_nxt = ang_full[31:30];
        t_nxt    = ang_full[30] ? (thh_pkg::ONE_Q30 - {1'b0, ang_full[29:0]})
                                : {1'b0, ang_full[29:0]};
      end
      thh_pkg::ST_POLY0: begin
        t2_nxt    = prod[61:30];
        hstep_nxt = '0;
      end
      thh_pkg::ST_HORN: hstep_nxt = hstep_r + 2'd1;
      thh_pkg::ST_ACCUM: begin
        acc_nxt = quad_r[1] ? (acc_r - term) : (acc_r + term);
        idx_nxt = idx_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= thh_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r     <= e_nxt;
    acc_r   <= acc_nxt;
    idx_r   <= idx_nxt;
    ang_r   <= ang_nxt;
    quad_r  <= quad_nxt;
    t_r     <= t_nxt;
    t2_r    <= t2_nxt;
    hstep_r <= hstep_nxt;
  end

  assign rom_addr = idx_nxt;
  assign acc      = acc_r;

endmodule

// ===== hw/rtl/tide_harmonic_height.sv =====
// ----------------------------------------------------------------------------
// tide_harmonic_height
// predicted tide height from a unix time, mean level plus harmonic constituents
// ----------------------------------------------------------------------------
// datapath: the one shared 32 x 32 multiplier serves every term in turn,
//   and each term uses it ten times (angle, square, polynomial, amplitude)
// input: ready only when idle, so no new time is taken until the last sum has gone to the result register
// reset: synchronous, active low; registers return to mean level 2.64 m and
//   the default epoch, no result pending, no clearing pass
module tide_harmonic_height #(
  parameter int NUM_TERMS = thh_pkg::NUM_TERMS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  thh_in_if.sink     in_chan,
  thh_out_if.source  out_chan,
  thh_cfg_if.sink    cfg_chan
);

  localparam int ACC_W = thh_pkg::acc_width(NUM_TERMS);
  localparam int SH_W  = ACC_W + 1;
  localparam logic signed [SH_W-1:0] H_MAX = SH_W'(thh_pkg::HEIGHT_MAX);
  localparam logic signed [SH_W-1:0] H_MIN = SH_W'(thh_pkg::HEIGHT_MIN);
  localparam logic signed [SH_W-1:0] H_RND = SH_W'(4096);

  // configuration registers
  logic [thh_pkg::LEVEL_W-1:0] mean_r;
  logic [thh_pkg::EPOCH_W-1:0] epoch_r;

  // result register towards the sink
  logic                         out_valid_r;
  logic [thh_pkg::HEIGHT_W-1:0] height_r;

  thh_pkg::thh_ctl_t     ctl;
  thh_pkg::thh_stat_t    stat;
  thh_pkg::thh_rom_t     rom_q;
  thh_pkg::thh_mul_req_t mul_req;
  logic [thh_pkg::IDX_W-1:0] rom_addr;
  logic [63:0]               prod;
  logic [ACC_W-1:0]          acc;
  logic [63:0]               elapsed;

  logic signed [SH_W-1:0]       acc_ext;
  logic signed [SH_W-1:0]       acc_rnd;
  logic [thh_pkg::HEIGHT_W-1:0] height_sat;

  // register writes are always taken; an unknown index is dropped
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_r  <= thh_pkg::MEAN_LEVEL_RST;
      epoch_r <= thh_pkg::EPOCH_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        thh_pkg::CFG_MEAN_LEVEL: mean_r  <= cfg_chan.data[thh_pkg::LEVEL_W-1:0];
        thh_pkg::CFG_EPOCH:      epoch_r <= cfg_chan.data[thh_pkg::EPOCH_W-1:0];
        default: ;
      endcase
    end
  end

  // elapsed seconds, two's complement, wraps modulo 2^64 like the angle
  assign elapsed = {{(64 - thh_pkg::TIME_W){in_chan.unix_time[thh_pkg::TIME_W-1]}},
                    in_chan.unix_time} - 64'(epoch_r);

  // a new item only while the sequencer is idle
  assign in_chan.ready = !stat.busy;
  assign ctl.start     = in_chan.valid && in_chan.ready;
  // the finished sum waits in the sequencer until the result register frees up
  assign ctl.out_free  = !out_valid_r || out_chan.ready;

  thh_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q_r  (rom_q)
  );

  thh_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod)
  );

  thh_seq #(
    .NUM_TERMS (NUM_TERMS),
    .ACC_W     (ACC_W)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .elapsed  (elapsed),
    .mean     (mean_r),
    .rom_q    (rom_q),
    .prod     (prod),
    .rom_addr (rom_addr),
    .mul_req  (mul_req),
    .acc      (acc),
    .stat     (stat)
  );

  // q8.29 sum (default 31 terms) to q4.16, round half up, then clamp to the output range
  assign acc_ext = {acc[ACC_W-1], acc};
  assign acc_rnd = (acc_ext + H_RND) >>> 13;

  always_comb begin
    if (acc_rnd > H_MAX) begin
      height_sat = H_MAX[thh_pkg::HEIGHT_W-1:0];
    end else if (acc_rnd < H_MIN) begin
      height_sat = H_MIN[thh_pkg::HEIGHT_W-1:0];
    end else begin
      height_sat = acc_rnd[thh_pkg::HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      height_r <= height_sat;
    end
  end

  assign out_chan.valid  = out_valid_r;
  assign out_chan.height = height_r;

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_chan.ready |-> !stat.done)
    else $error("result overwritten while still pending");

  // an input transfer always starts the sequencer
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |=> stat.busy)
    else $error("input transfer did not start the term loop");

  // completion always shows up at the output
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> out_valid_r)
    else $error("finished sum not presented as a result");

  // no transfer can land while terms are being summed
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stat.busy |-> !in_chan.ready)
    else $error("input ready during term loop");

endmodule

// ===== sim/tb_tide_harmonic_height.sv =====
// ----------------------------------------------------------------------------
// tb_tide_harmonic_height
// self-checking bench for the harmonic tide height predictor: a queue-fed
// driver sends unix times, a bit-exact fixed-point predictor works out the
// height of each accepted time, and a monitor compares every result transfer
// with the oldest outstanding height, over several register settings and
// idle/stall mixes
// ----------------------------------------------------------------------------
module tb_tide_harmonic_height;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_TERMS = thh_pkg::NUM_TERMS_DEF;

  // time for one evaluation: every term in turn, plus entry and exit
  localparam int LATENCY      = 12 * N_TERMS + 2;
  localparam int DRAIN_CYCLES = LATENCY + 32;
  // cycles with no transfer of any kind before the run is declared hung
  localparam int IDLE_LIMIT   = 8 * LATENCY + 2000;
  localparam int MAX_REPORTS  = 20;

  // register indexes with no register behind them
  localparam logic [thh_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = 4'd2;
  localparam logic [thh_pkg::CFG_IDX_W-1:0] CFG_LAST_UNMAPPED  = 4'd15;

  // sine polynomial coefficients in q30, odd powers through t^9
  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598668;
  localparam logic [63:0] SIN_C5 = 64'd85569306;
  localparam logic [63:0] SIN_C7 = 64'd5026995;
  localparam logic [63:0] SIN_C9 = 64'd172272;

  // degrees per hour * 1e7 -> 0.64 turns per second divisor (3600 * 360 * 1e7)
  localparam logic [127:0] TURN_DIVISOR = 128'd12960000000000;

  logic clk = 1'b0;
  logic rst_n;

  thh_in_if  in_if ();
  thh_out_if out_if ();
  thh_cfg_if cfg_if ();

  tide_harmonic_height #(
    .NUM_TERMS(N_TERMS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // constituent table in decimal units: deg/h * 1e7, deg * 1e3, metres * 1e4
  int unsigned speed_dec [0:30] = '{
    289841042, 300000000, 284397295, 300821373, 150410686, 139430356,
    149589314, 133986609, 279682084, 285125831, 278953548, 295284789,
    299589333, 310158958, 294556253, 155854433, 161391017, 128542862,
    134715145, 579682084, 589841042, 574238337, 590662415, 600000000,
    869523127, 864079380, 879682084, 440251729, 429271398, 10980331,
    5443747
  };
  int unsigned lag_dec [0:30] = '{
    209601, 30617, 263418, 196250, 357212, 59267, 354719, 79892,
    187004, 330693, 313497, 324568, 15603, 14171, 245613, 22363,
    77357, 127521, 152544, 38983, 232210, 87083, 39766, 20681,
    346092, 33689, 165004, 128877, 201290, 104409, 48050
  };
  int unsigned ampl_dec [0:30] = '{
    16236, 4758, 2846, 1624, 1031, 1272, 361, 415, 913, 824, 306,
    1087, 224, 301, 475, 63, 49, 65, 83, 525, 225, 184, 63, 9,
    92, 48, 70, 198, 266, 87, 75
  };

  // fixed-point constituents; slots past the table stay zero
  logic [63:0] speed_turns [0:thh_pkg::ROM_SLOTS-1];
  logic [31:0] lag_turns   [0:thh_pkg::ROM_SLOTS-1];
  longint      ampl_q14    [0:thh_pkg::ROM_SLOTS-1];

  // shadow copy of the block's registers
  logic signed [thh_pkg::LEVEL_W-1:0] level_reg;
  logic [thh_pkg::EPOCH_W-1:0]        epoch_reg;

  logic [thh_pkg::TIME_W-1:0]   time_q [$];    // unix times waiting to be driven
  logic [thh_pkg::HEIGHT_W-1:0] height_q [$];  // heights owed by the block, oldest first

  int send_idle_pct;
  int stall_pct;
  int error_count;
  int idle_cycles;

  function automatic void build_constituents();
    logic [127:0] n;
    logic [63:0]  w;
    int           k;
    for (k = 0; k < thh_pkg::ROM_SLOTS; k++) begin
      speed_turns[k] = '0;
      lag_turns[k]   = '0;
      ampl_q14[k]    = 0;
    end
    for (k = 0; k < 31; k++) begin
      // round to nearest; the divisor is even so half of it is exact
      n = (128'(speed_dec[k]) << 64) + (TURN_DIVISOR >> 1);
      speed_turns[k] = 64'(n / TURN_DIVISOR);
      w = (64'(lag_dec[k]) << 32) + 64'd180000;
      lag_turns[k] = 32'(w / 64'd360000);
      w = 64'(ampl_dec[k]) * 64'd16384 + 64'd5000;
      ampl_q14[k] = longint'(w / 64'd10000);
    end
  endfunction

  // cosine of a 0.64 turn angle, q1.15, via the sine polynomial a quarter on
  function automatic logic signed [15:0] harmonic_cos(input logic [63:0] ang);
    logic [63:0] a;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] mag;
    logic [1:0]  quad;
    a    = ang + 64'h4000_0000_0000_0000;
    quad = a[63:62];
    t    = {34'd0, a[61:32]};
    if (quad[0]) begin
      t = 64'h4000_0000 - t;
    end
    t2  = (t * t) >> 30;
    p   = SIN_C9;
    p   = SIN_C7 - ((p * t2) >> 30);
    p   = SIN_C5 - ((p * t2) >> 30);
    p   = SIN_C3 - ((p * t2) >> 30);
    p   = SIN_C1 - ((p * t2) >> 30);
    mag = (((p * t) >> 30) + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return quad[1] ? -$signed(mag[15:0]) : $signed(mag[15:0]);
  endfunction

  // mean level plus every constituent, rounded to q4.16 and saturated
  function automatic logic [thh_pkg::HEIGHT_W-1:0] tide_height(
    input logic [thh_pkg::TIME_W-1:0] ut);
    logic [63:0] elapsed;
    logic [63:0] ang;
    longint      acc;
    longint      h;
    int          i;
    int          k;
    // two's complement elapsed seconds, the angle wraps exactly mod 2^64
    elapsed = {{24{ut[thh_pkg::TIME_W-1]}}, ut} - {25'd0, epoch_reg};
    acc     = {{44{level_reg[thh_pkg::LEVEL_W-1]}}, level_reg};
    acc     = acc * 8192;
    for (i = 0; i < N_TERMS; i++) begin
      k   = i % thh_pkg::ROM_SLOTS;
      ang = speed_turns[k] * elapsed - {lag_turns[k], 32'd0};
      acc = acc + ampl_q14[k] * harmonic_cos(ang);
    end
    h = (acc + 4096) >>> 13;
    if (h > thh_pkg::HEIGHT_MAX) begin
      h = thh_pkg::HEIGHT_MAX;
    end
    if (h < thh_pkg::HEIGHT_MIN) begin
      h = thh_pkg::HEIGHT_MIN;
    end
    return h[thh_pkg::HEIGHT_W-1:0];
  endfunction

  // mostly plausible times around now and around the epoch, the rest raw bits
  function automatic logic [thh_pkg::TIME_W-1:0] random_time();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    case ($urandom_range(9, 0))
      0, 1, 2: return {8'd0, bits[31:0]};
      3, 4:    return {1'b0, epoch_reg} + {{8{bits[31]}}, bits[31:0]};
      5, 6:    return {1'b0, epoch_reg} + {{22{bits[17]}}, bits[17:0]};
      default: return bits[thh_pkg::TIME_W-1:0];
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // input driver: holds an item until its transfer, predicts at the transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        height_q.push_back(tide_height(in_if.unix_time));
      end
      // a new item may go out once the bus is free or its item has moved
      if (!in_if.valid || in_if.ready) begin
        if (time_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          in_if.valid     <= 1'b1;
          in_if.unix_time <= time_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: checks each height transfer, stalls at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic [thh_pkg::HEIGHT_W-1:0] want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (height_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: unexpected height transfer, expected none, actual %0d",
                     $time, $signed(out_if.height));
          end
        end else begin
          want = height_q.pop_front();
          if (out_if.height !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("%0t: height mismatch, expected %0d, actual %0d",
                       $time, $signed(want), $signed(out_if.height));
            end
          end
        end
      end
      out_if.ready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // register write; the caller drops valid after the last write of a batch
  task automatic write_reg(input logic [thh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [thh_pkg::CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      thh_pkg::CFG_MEAN_LEVEL: level_reg = val[thh_pkg::LEVEL_W-1:0];
      thh_pkg::CFG_EPOCH:      epoch_reg = val[thh_pkg::EPOCH_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every queued time has moved and every height has come back
  task automatic wait_drained();
    while (time_q.size() != 0 || in_if.valid === 1'b1 || height_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // one setting: mean level (upper data bits are junk), epoch, a write to a
  // hole in the register map, then a batch of random times
  task automatic run_phase(input logic [thh_pkg::LEVEL_W-1:0] level,
                           input logic [thh_pkg::EPOCH_W-1:0] epoch,
                           input int send_pct, input int stall, input int count);
    int n;
    write_reg(thh_pkg::CFG_MEAN_LEVEL, {19'($urandom), level});
    write_reg(thh_pkg::CFG_EPOCH, epoch);
    write_reg(4'($urandom_range(CFG_LAST_UNMAPPED, CFG_FIRST_UNMAPPED)),
              {7'($urandom), $urandom});
    cfg_if.valid  <= 1'b0;
    send_idle_pct  = send_pct;
    stall_pct      = stall;
    for (n = 0; n < count; n++) begin
      time_q.push_back(random_time());
    end
    wait_drained();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.unix_time = '0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    error_count     = 0;
    idle_cycles     = 0;
    level_reg       = thh_pkg::MEAN_LEVEL_RST;
    epoch_reg       = thh_pkg::EPOCH_RST;
    build_constituents();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, back to back: time extremes, the epoch itself and its
    // neighbours, quarter and half days on, past 32 bits, alternating bits
    time_q = '{
      40'd0, 40'd1, 40'hff_ffff_ffff, 40'h7f_ffff_ffff, 40'h80_0000_0000,
      {1'b0, thh_pkg::EPOCH_RST}, {1'b0, thh_pkg::EPOCH_RST} + 40'd1,
      {1'b0, thh_pkg::EPOCH_RST} - 40'd1,
      {1'b0, thh_pkg::EPOCH_RST} + 40'd21600, {1'b0, thh_pkg::EPOCH_RST} + 40'd43200,
      40'h00_ffff_ffff, 40'h01_0000_0000, 40'h55_5555_5555, 40'haa_aaaa_aaaa,
      40'd1700000000, 40'h00_7fff_ffff
    };
    wait_drained();

    // top mean level saturates high, bottom saturates low, extreme epochs
    run_phase(20'h7ffff, '0, 0, 0, 150);
    run_phase(20'h80000, {thh_pkg::EPOCH_W{1'b1}}, 62, 0, 150);
    run_phase(20'($urandom), {7'($urandom), $urandom}, 0, 62, 200);
    run_phase('0, thh_pkg::EPOCH_RST, 15, 15, 200);
    run_phase(20'($urandom), {7'($urandom), $urandom}, 0, 0, 150);
    run_phase(thh_pkg::MEAN_LEVEL_RST, {7'($urandom), $urandom}, 62, 62, 150);

    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
